### hdl/swmv_pkg.sv
// ----------------------------------------------------------------------------
// swmv_pkg: shared types for the sliding window mean/variance block
// Request types of both channels, per-axis sample vector, square helper.
// ----------------------------------------------------------------------------
`default_nettype none

package swmv_pkg;

  localparam int unsigned AXES     = 3;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned MEAN_W   = 8;
  localparam int unsigned VAR_W    = 15;
  localparam int unsigned SQUARE_W = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [AXES-1:0]         axis_samples_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_req_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [MEAN_W-1:0] mean_z;
    logic [VAR_W-1:0]         variance_x;
    logic [VAR_W-1:0]         variance_y;
    logic [VAR_W-1:0]         variance_z;
  } out_req_t;

  // (-128)^2 = 16384 still fits in 15 bits
  function automatic logic [SQUARE_W-1:0] square8(input logic signed [SAMPLE_W-1:0] v);
    logic signed [2*SAMPLE_W-1:0] p;
    p = v * v;
    return p[SQUARE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/swmv_ram.sv
// ----------------------------------------------------------------------------
// swmv_ram: generic single-write, single-read RAM
// Registered read; a read and write to the same address return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/swmv_window.sv
// ----------------------------------------------------------------------------
// swmv_window: delay line and running sums
// Writes each sample into the history RAM while reading back the sample it
// replaces, then updates the per-axis sum and sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_window
  import swmv_pkg::*;
#(
  parameter int unsigned WINDOW = 32,
  parameter int unsigned SUM_W  = 13,
  parameter int unsigned SQ_W   = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire axis_samples_t                 in_samples_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [AXES-1:0][SUM_W-1:0]         out_sum_o,
  output logic [AXES-1:0][SQ_W-1:0]          out_sq_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              full_q, full_d;
  logic              accept;

  logic              s1_valid_q;
  logic              s1_full_q;
  axis_samples_t     s1_sample_q;
  axis_samples_t     old_samples;
  logic              s2_valid_q;
  logic              s2_en;
  logic              s1_move;

  logic signed [SUM_W-1:0] sum_q [AXES];
  logic signed [SUM_W-1:0] sum_d [AXES];
  logic        [SQ_W-1:0]  sq_q  [AXES];
  logic        [SQ_W-1:0]  sq_d  [AXES];

  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s2_en;
  assign in_ready_o = !s1_valid_q || s2_en;
  assign accept     = in_valid_i && in_ready_o;

  swmv_ram #(
    .WIDTH (AXES * SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (in_samples_i),
    .re_i    (accept),
    .raddr_i (slot_q),
    .rdata_o (old_samples)
  );

  always_comb begin
    slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
    full_d = full_q || (slot_q == LAST_SLOT);
  end

  // the replaced sample only counts once the window has been filled
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_d[a] = sum_q[a] + SUM_W'($signed(s1_sample_q[a]))
                 - (s1_full_q ? SUM_W'($signed(old_samples[a])) : '0);
      sq_d[a]  = sq_q[a] + SQ_W'(square8($signed(s1_sample_q[a])))
                 - (s1_full_q ? SQ_W'(square8($signed(old_samples[a]))) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      full_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
        sq_q[a]  <= '0;
      end
    end else begin
      if (accept) begin
        slot_q <= slot_d;
        full_q <= full_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        for (int a = 0; a < AXES; a++) begin
          sum_q[a] <= sum_d[a];
          sq_q[a]  <= sq_d[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= in_samples_i;
      s1_full_q   <= full_q;
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      out_sum_o[a] = sum_q[a];
      out_sq_o[a]  = sq_q[a];
    end
  end

  assign out_valid_o = s2_valid_q;

  a_full_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("window full flag dropped");

  a_slot_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && slot_q != LAST_SLOT |=> slot_q == $past(slot_q) + 1'b1)
    else $error("write slot did not advance by one");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request missing from stage 1");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_en |=> s1_valid_q && $stable(s1_sample_q))
    else $error("stage 1 request lost while stalled");

endmodule

`default_nettype wire

### hdl/swmv_stats.sv
// ----------------------------------------------------------------------------
// swmv_stats: mean and variance from the running sums
// Divides by WINDOW through reciprocal multiplies, squares the mean and
// subtracts it from the mean of squares, in three registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_stats
  import swmv_pkg::*;
#(
  parameter int unsigned WINDOW = 32,
  parameter int unsigned SUM_W  = 13,
  parameter int unsigned SQ_W   = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [AXES-1:0][SUM_W-1:0]    in_sum_i,
  input  wire logic [AXES-1:0][SQ_W-1:0]     in_sq_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [AXES-1:0][MEAN_W-1:0]        out_mean_o,
  output logic [AXES-1:0][VAR_W-1:0]         out_var_o
);

  localparam int unsigned L = $clog2(WINDOW);

  // floor(x / WINDOW) == (x * M) >> (N + L) for every N-bit x,
  // with M = ceil(2^(N+L) / WINDOW)
  localparam int unsigned SUM_SHIFT = SUM_W + L;
  localparam int unsigned SUM_M_W   = SUM_W + 2;
  localparam int unsigned SUM_P_W   = SUM_W + SUM_M_W;
  localparam logic [63:0] SUM_M_FULL =
    ((64'd1 << SUM_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SUM_M_W-1:0] SUM_M = SUM_M_FULL[SUM_M_W-1:0];

  localparam int unsigned SQ_SHIFT = SQ_W + L;
  localparam int unsigned SQ_M_W   = SQ_W + 2;
  localparam int unsigned SQ_P_W   = SQ_W + SQ_M_W;
  localparam logic [63:0] SQ_M_FULL =
    ((64'd1 << SQ_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SQ_M_W-1:0] SQ_M = SQ_M_FULL[SQ_M_W-1:0];

  logic v3_q, v4_q, vo_q;
  logic en3, en4, eno;

  logic [SUM_W-1:0]   mag      [AXES];
  logic               neg3_q   [AXES];
  logic [SUM_P_W-1:0] sump3_q  [AXES];
  logic [SQ_P_W-1:0]  sqp3_q   [AXES];

  logic [MEAN_W-1:0]  quot     [AXES];
  logic [2*MEAN_W-1:0] qq      [AXES];
  logic [MEAN_W-1:0]  mean4_q  [AXES];
  logic [VAR_W-1:0]   sqavg4_q [AXES];
  logic [VAR_W-1:0]   msq4_q   [AXES];

  logic [MEAN_W-1:0]  meano_q  [AXES];
  logic [VAR_W-1:0]   varo_q   [AXES];

  assign eno        = !vo_q || out_ready_i;
  assign en4        = !v4_q || eno;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  // truncation toward zero: divide the magnitude, restore the sign later
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      mag[a]  = in_sum_i[a][SUM_W-1] ? SUM_W'(-in_sum_i[a]) : in_sum_i[a];
      quot[a] = sump3_q[a][SUM_SHIFT +: MEAN_W];
      qq[a]   = quot[a] * quot[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= in_valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (eno) begin
        vo_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXES; a++) begin
      if (en3) begin
        neg3_q[a]  <= in_sum_i[a][SUM_W-1];
        sump3_q[a] <= SUM_P_W'(mag[a]) * SUM_P_W'(SUM_M);
        sqp3_q[a]  <= SQ_P_W'(in_sq_i[a]) * SQ_P_W'(SQ_M);
      end
      if (en4) begin
        mean4_q[a]  <= neg3_q[a] ? MEAN_W'(-quot[a]) : quot[a];
        sqavg4_q[a] <= sqp3_q[a][SQ_SHIFT +: VAR_W];
        msq4_q[a]   <= qq[a][VAR_W-1:0];
      end
      if (eno) begin
        meano_q[a] <= mean4_q[a];
        varo_q[a]  <= sqavg4_q[a] - msq4_q[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      out_mean_o[a] = meano_q[a];
      out_var_o[a]  = varo_q[a];
    end
  end

  assign out_valid_o = vo_q;

  a_var_nonneg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (msq4_q[0] <= sqavg4_q[0]) && (msq4_q[1] <= sqavg4_q[1])
             && (msq4_q[2] <= sqavg4_q[2]))
    else $error("squared mean exceeds mean of squares");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v3_q && v4_q && vo_q)
    else $error("stats pipeline stalled with a bubble");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vo_q) |-> $past(v4_q))
    else $error("result appeared without a stage 4 request");

endmodule

`default_nettype wire

### hdl/sliding_window_mean_variance.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_variance: per-axis moving mean and variance
// Three-axis signed 8-bit samples in, window mean and variance per axis out.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              request
//   in        input      in_valid_i/in_ready_o  in_req_i  (sample_x/y/z)
//   out       output     out_valid_o/out_ready_i out_req_o (mean_*, variance_*)
//
// One request per cycle sustained while out_ready_i stays high; after its request
// is taken a result passes through history RAM read, sum update, reciprocal
// multiply, mean square and variance subtract, each a registered stage.
// No clearing pass after reset: the replaced history entry is only used once
// the window has wrapped, so unwritten data never reaches the sums.
// Stages with bubbles keep taking requests while out_ready_i is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mean_variance
  import swmv_pkg::*;
#(
  parameter int unsigned WINDOW = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire in_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_req_t     out_req_o
);

  localparam int unsigned SUM_W = $clog2(WINDOW) + SAMPLE_W;
  localparam int unsigned SQ_W  = $clog2(WINDOW) + SQUARE_W;

  axis_samples_t                samples;
  logic                         win_valid;
  logic                         win_ready;
  logic [AXES-1:0][SUM_W-1:0]   win_sum;
  logic [AXES-1:0][SQ_W-1:0]    win_sq;
  logic [AXES-1:0][MEAN_W-1:0]  mean;
  logic [AXES-1:0][VAR_W-1:0]   variance;

  assign samples[0] = in_req_i.sample_x;
  assign samples[1] = in_req_i.sample_y;
  assign samples[2] = in_req_i.sample_z;

  swmv_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .SQ_W   (SQ_W)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_samples_i (samples),
    .out_valid_o  (win_valid),
    .out_ready_i  (win_ready),
    .out_sum_o    (win_sum),
    .out_sq_o     (win_sq)
  );

  swmv_stats #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .SQ_W   (SQ_W)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .in_sum_i    (win_sum),
    .in_sq_i     (win_sq),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_mean_o  (mean),
    .out_var_o   (variance)
  );

  always_comb begin
    out_req_o.mean_x     = mean[0];
    out_req_o.mean_y     = mean[1];
    out_req_o.mean_z     = mean[2];
    out_req_o.variance_x = variance[0];
    out_req_o.variance_y = variance[1];
    out_req_o.variance_z = variance[2];
  end

endmodule

`default_nettype wire
